// File: hdl/sgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

	// Width of the group size register and of one list value.
	localparam int GSW = 5;
	localparam int VW  = 32;

	// Group size after reset.
	localparam logic [GSW-1:0] GROUP_SIZE_RESET = GSW'(2);

	// Control states: taking words, or reading a group or a list tail out of the buffer.
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

// File: hdl/stream_group_reverser.sv
`timescale 1ns / 1ps
`default_nettype none

// Group reverser for a stream of signed 32-bit list values.
// Input words arrive on s_tdata (the value) with s_tlast marking the last word
// of a list. Each complete group of group_size words is sent out on m_tdata
// newest first; a short tail at the end of a list is sent in arrival order.
// m_tlast marks the last word caused by one input word, m_tuser the last word
// of the whole list. group_size is written through cfg_wen / cfg_wdata; the
// user must write it only while the block is idle, and the block itself does
// not enforce this. Zero acts as one and values above MAX_GROUP saturate.
// Words are held in one buffer memory with a registered read. Input words are
// taken one per cycle while idle; a word that closes a group or a list starts
// a read-out of n words at one word per cycle when the output does not stall.
// No input is taken during a read-out. The read register doubles as the
// output register: while it waits on m_tready the read-out pauses, and the
// input side stays open once the read-out has issued its last read.
// Reset clears the fill count and the output valid and sets group_size to 2;
// no clearing pass is needed since only written entries are ever read.
module stream_group_reverser #(
	parameter int MAX_GROUP = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// Configuration: group_size.
	input  wire                   cfg_wen,
	input  wire [sgr_pkg::GSW-1:0] cfg_wdata,
	// Input words.
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [sgr_pkg::VW-1:0] s_tdata,   // [31:0] value
	input  wire                   s_tlast,   // is_final
	// Result words.
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [sgr_pkg::VW-1:0] m_tdata,  // [31:0] value_res
	output logic                  m_tlast,   // run_last
	output logic                  m_tuser    // list_end
);
	import sgr_pkg::*;

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int SW = ((CW > GSW) ? CW : GSW) + 1;
	localparam logic [SW-1:0] MAX_S = SW'(MAX_GROUP);

	logic [GSW-1:0] group_size_q;
	state_t         state_q, state_nxt;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  idx_q;
	logic           rev_q;
	logic           fin_q;

	logic [VW-1:0]  mem [MAX_GROUP];
	logic [VW-1:0]  rdata_q;
	logic           valid_q;
	logic           last_q;
	logic           end_q;

	logic [SW-1:0]  gs_ext;
	logic [SW-1:0]  size_eff;
	logic [CW-1:0]  n_new;
	logic           accept;
	logic           flush;
	logic           complete;
	logic           issue;
	logic           rd_last;
	logic [CW-1:0]  rev_addr;
	logic [AW-1:0]  rd_addr;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RESET;
		end else if (cfg_wen) begin
			group_size_q <= cfg_wdata;
		end
	end

	// Effective group size: zero counts as one, large values saturate.
	always_comb begin
		gs_ext = SW'(group_size_q);
		if (gs_ext == '0) begin
			size_eff = SW'(1);
		end else if (gs_ext > MAX_S) begin
			size_eff = MAX_S;
		end else begin
			size_eff = gs_ext;
		end
	end

	// Decide on each accepted word whether it starts a read-out.
	assign accept   = s_tvalid && s_tready;
	assign n_new    = fill_q + CW'(1);
	assign complete = SW'(n_new) >= size_eff;
	assign flush    = complete || s_tlast;

	// Read-out addressing: newest first for a full group, else oldest first.
	assign rd_last  = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign rev_addr = cnt_q - CW'(1) - CW'(idx_q);
	assign rd_addr  = rev_q ? rev_addr[AW-1:0] : idx_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && flush) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && rd_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_DRAIN: begin
				issue = !valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				fill_q <= flush ? '0 : n_new;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + AW'(1);
			end
			if (issue) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Read-out parameters latched with the word that closes a run.
	always_ff @(posedge clk) begin
		if (accept && flush) begin
			cnt_q <= n_new;
			rev_q <= complete;
			fin_q <= s_tlast;
		end
		if (issue) begin
			last_q <= rd_last;
			end_q  <= rd_last && fin_q;
		end
	end

	// Buffer memory: write on accept, registered read during read-out.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[fill_q[AW-1:0]] <= s_tdata;
		end
		if (issue) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// The read register doubles as the output stage.
	assign m_tvalid = valid_q;
	assign m_tdata  = rdata_q;
	assign m_tlast  = last_q;
	assign m_tuser  = end_q;

`ifndef SYNTHESIS
	// The fill count never reaches the buffer depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(fill_q) < MAX_S)
		else $error("fill count out of range");

	// During a read-out the buffer is already marked empty.
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> fill_q == '0)
		else $error("buffer not empty during read-out");

	// The read index stays inside the run being read out.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> CW'(idx_q) < cnt_q)
		else $error("read index beyond run");

	// The end of a list is always the end of a run.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("list end without run end");
`endif

endmodule

`default_nettype wire

// File: dv/tb_stream_group_reverser.sv
`timescale 1ns / 1ps

module tb_stream_group_reverser;

	localparam int MAX_GROUP  = 16;
	localparam int CYCLE_CAP  = 400000;
	localparam int SETTLE     = 8;
	localparam int PLAN_STEPS = 12;
	localparam int PLAN_WORDS = 38;

	// One result word as the block should send it.
	typedef struct {
		logic [sgr_pkg::VW-1:0] value;
		logic                   run_last;
		logic                   list_end;
	} out_word_t;

	// Mirrors the group buffer and the size register, and keeps the result
	// words that are owed in the order the block must send them.
	class group_reverse_tracker;
		logic [sgr_pkg::VW-1:0]  held [MAX_GROUP];
		int                      held_count;
		logic [sgr_pkg::GSW-1:0] size_reg;
		out_word_t               due_words [$];
		int                      faults;

		function new();
			held_count = 0;
			size_reg   = sgr_pkg::GROUP_SIZE_RESET;
			faults     = 0;
		endfunction

		// Zero acts as one; anything above the buffer depth saturates.
		function int live_size();
			if (size_reg == 0)
				return 1;
			if (size_reg > MAX_GROUP)
				return MAX_GROUP;
			return size_reg;
		endfunction

		// An accepted input word: store it and queue whatever it releases.
		function void take_word(logic [sgr_pkg::VW-1:0] v, logic fin);
			int        n;
			int        i;
			out_word_t w;
			if (held_count >= MAX_GROUP)
				held_count = MAX_GROUP - 1;
			held[held_count] = v;
			held_count++;
			n = held_count;
			if (n >= live_size()) begin
				// Complete group goes out newest first.
				for (i = 0; i < n; i++) begin
					w.value    = held[n - 1 - i];
					w.run_last = (i == n - 1);
					w.list_end = w.run_last & fin;
					due_words.push_back(w);
				end
				held_count = 0;
			end else if (fin) begin
				// Short tail at the end of a list keeps its arrival order.
				for (i = 0; i < n; i++) begin
					w.value    = held[i];
					w.run_last = (i == n - 1);
					w.list_end = w.run_last;
					due_words.push_back(w);
				end
				held_count = 0;
			end
		endfunction

		// An accepted result word: compare it with the oldest word owed.
		function void match_word(logic [sgr_pkg::VW-1:0] v, logic last, logic lend);
			out_word_t w;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word value=%h last=%b end=%b", $time, v, last, lend);
				faults++;
				return;
			end
			w = due_words.pop_front();
			if (v !== w.value) begin
				$display("%0t: value expected %h, got %h", $time, w.value, v);
				faults++;
			end
			if (last !== w.run_last) begin
				$display("%0t: tlast expected %b, got %b", $time, w.run_last, last);
				faults++;
			end
			if (lend !== w.list_end) begin
				$display("%0t: tuser expected %b, got %b", $time, w.list_end, lend);
				faults++;
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_wen   = 1'b0;
	logic [sgr_pkg::GSW-1:0] cfg_wdata = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [sgr_pkg::VW-1:0]  s_tdata   = '0;   // [31:0] value
	logic                    s_tlast   = 1'b0; // is_final
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [sgr_pkg::VW-1:0]  m_tdata;          // [31:0] value_res
	logic                    m_tlast;          // run_last
	logic                    m_tuser;          // list_end

	group_reverse_tracker board = new();
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int cycle_count    = 0;

	stream_group_reverser #(
		.MAX_GROUP(MAX_GROUP)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: check each accepted word, then pick the next tready.
	// A requested hold-off keeps tready low until its count runs out.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.match_word(m_tdata, m_tlast, m_tuser);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Extremes turn up often; otherwise any 32-bit pattern.
	function automatic logic [sgr_pkg::VW-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Offer one word, with random idle cycles ahead of it, until it is taken.
	task automatic send_word(input logic [sgr_pkg::VW-1:0] v, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.take_word(v, fin);
	endtask

	// Send lists of random length; the last list may be cut off unflagged,
	// so words stay held across the next size change.
	task automatic send_lists(input int words, input int max_len);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < words) begin
			len = $urandom_range(max_len, 1);
			for (k = 0; k < len && sent < words; k++) begin
				send_word(pick_value(), k == len - 1);
				sent++;
			end
		end
	endtask

	// Change group_size only once every owed word is out and the block
	// has had time to finish storing the last input word.
	task automatic write_size(input logic [sgr_pkg::GSW-1:0] gs);
		s_tvalid <= 1'b0;
		while (board.due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= gs;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.size_reg = gs;
	endtask

	initial begin
		int                      i;
		int                      k;
		logic [sgr_pkg::GSW-1:0] gs;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size of two: a full group, then a one-word tail.
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);

		// Size one passes words through.
		write_size(5'd1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h1234_5678, 1'b1);

		// Size zero acts as one.
		write_size(5'd0);
		send_word(32'hA5A5_5A5A, 1'b1);

		// Hold three words, lower the size, and let a final word flush all four.
		write_size(5'd4);
		send_word(32'h0000_0011, 1'b0);
		send_word(32'hFFFF_FF22, 1'b0);
		send_word(32'h0000_0033, 1'b0);
		write_size(5'd2);
		send_word(32'h8000_0044, 1'b1);

		// Size above the buffer depth saturates; the final word closes a group.
		write_size(5'd31);
		for (k = 0; k < MAX_GROUP; k++)
			send_word(pick_value(), k == MAX_GROUP - 1);

		// Random lists under a run of sizes and idling patterns.
		for (i = 0; i < PLAN_STEPS; i++) begin
			case (i)
				0: gs = 5'd16;
				1: gs = 5'd1;
				2: gs = 5'd31;
				3: gs = 5'd0;
				4: gs = 5'd17;
				5: gs = 5'd4;
				6: gs = 5'd2;
				7: gs = 5'd3;
				default: gs = $urandom_range(31);
			endcase
			write_size(gs);
			case (i % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct  = 22;
					recv_stall_pct = 22;
				end
			endcase
			// Long receiver hold-off while words keep coming, so input stalls.
			if (i == 4)
				hold_left = 300;
			send_lists(PLAN_WORDS, 2 * board.live_size() + 3);
		end

		// Drain and keep watching for anything stray.
		s_tvalid       <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (board.due_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (board.faults == 0 && board.due_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: stream_group_reverser.f
hdl/sgr_pkg.sv
hdl/stream_group_reverser.sv
dv/tb_stream_group_reverser.sv
